@@ sv/dpb_pkg.sv @@
`default_nettype none

package dpb_pkg;

  // Field widths of the item ports and the configuration registers.
  localparam int unsigned DepthW   = 16;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned PixW     = 12;
  localparam int unsigned CenterW  = 16;
  localparam int unsigned InvW     = 24;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Largest supported frame dimension.
  localparam int unsigned MaxDimDefault = 4096;

  // The scaled product carries 24 fraction bits from the reciprocal focal length.
  localparam int unsigned RoundShift = 24;

  // Saturation limits on the rounded magnitude.
  localparam logic [CoordW:0] NegMagLimit = 33'h0_8000_0000;
  localparam logic [CoordW:0] PosMagLimit = 33'h0_7FFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_COL    = 3'd0,
    CFG_CENTER_ROW    = 3'd1,
    CFG_INV_FOCAL_COL = 3'd2,
    CFG_INV_FOCAL_ROW = 3'd3,
    CFG_MAX_DEPTH     = 3'd4,
    CFG_FRAME_WIDTH   = 3'd5,
    CFG_FRAME_HEIGHT  = 3'd6
  } cfg_idx_e;

  // Configuration register set.
  typedef struct packed {
    logic [CenterW-1:0] center_col;
    logic [CenterW-1:0] center_row;
    logic [InvW-1:0]    inv_focal_col;
    logic [InvW-1:0]    inv_focal_row;
    logic [DepthW-1:0]  max_depth;
    logic [DimW-1:0]    frame_width;
    logic [DimW-1:0]    frame_height;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    center_col:    16'd5120,
    center_row:    16'd3840,
    inv_focal_col: 24'd27962,
    inv_focal_row: 24'd27962,
    max_depth:     16'd2000,
    frame_width:   13'd640,
    frame_height:  13'd480
  };

  // Which coordinate the datapath is working on.
  typedef enum logic {
    AXIS_COL = 1'b0,
    AXIS_ROW = 1'b1
  } axis_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_MUL_DEPTH = 3'd1,
    ST_MUL_LO    = 3'd2,
    ST_MUL_HI    = 3'd3,
    ST_ROUND     = 3'd4,
    ST_EMIT      = 3'd5
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    axis_e axis;
    logic  mul_depth;
    logic  mul_lo;
    logic  mul_hi;
    logic  round;
    logic  emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic keep;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/dpb_cfg.sv @@
`default_nettype none

module dpb_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dpb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dpb_pkg::CfgDataW-1:0]  cfg_data_i,
  output dpb_pkg::cfg_t                      cfg_o
);

  dpb_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register write decode; data is truncated to each register's width.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (dpb_pkg::cfg_idx_e'(cfg_index_i))
        dpb_pkg::CFG_CENTER_COL:    cfg_d.center_col    = cfg_data_i[dpb_pkg::CenterW-1:0];
        dpb_pkg::CFG_CENTER_ROW:    cfg_d.center_row    = cfg_data_i[dpb_pkg::CenterW-1:0];
        dpb_pkg::CFG_INV_FOCAL_COL: cfg_d.inv_focal_col = cfg_data_i[dpb_pkg::InvW-1:0];
        dpb_pkg::CFG_INV_FOCAL_ROW: cfg_d.inv_focal_row = cfg_data_i[dpb_pkg::InvW-1:0];
        dpb_pkg::CFG_MAX_DEPTH:     cfg_d.max_depth     = cfg_data_i[dpb_pkg::DepthW-1:0];
        dpb_pkg::CFG_FRAME_WIDTH:   cfg_d.frame_width   = cfg_data_i[dpb_pkg::DimW-1:0];
        dpb_pkg::CFG_FRAME_HEIGHT:  cfg_d.frame_height  = cfg_data_i[dpb_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dpb_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/dpb_ctrl.sv @@
`default_nettype none

module dpb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire dpb_pkg::stat_t  stat_i,
  output dpb_pkg::cmd_t        cmd_o
);

  dpb_pkg::state_e state_q, state_d;
  dpb_pkg::axis_e  axis_q, axis_d;

  // Next state: each kept pixel runs the multiply sequence once per axis.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      dpb_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.keep) begin
          state_d = dpb_pkg::ST_MUL_DEPTH;
          axis_d  = dpb_pkg::AXIS_COL;
        end
      end
      dpb_pkg::ST_MUL_DEPTH: state_d = dpb_pkg::ST_MUL_LO;
      dpb_pkg::ST_MUL_LO:    state_d = dpb_pkg::ST_MUL_HI;
      dpb_pkg::ST_MUL_HI:    state_d = dpb_pkg::ST_ROUND;
      dpb_pkg::ST_ROUND: begin
        if (axis_q == dpb_pkg::AXIS_COL) begin
          state_d = dpb_pkg::ST_MUL_DEPTH;
          axis_d  = dpb_pkg::AXIS_ROW;
        end else begin
          state_d = dpb_pkg::ST_EMIT;
        end
      end
      dpb_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = dpb_pkg::ST_IDLE;
        end
      end
      default: state_d = dpb_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      dpb_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      dpb_pkg::ST_MUL_DEPTH: cmd_o.mul_depth = 1'b1;
      dpb_pkg::ST_MUL_LO:    cmd_o.mul_lo    = 1'b1;
      dpb_pkg::ST_MUL_HI:    cmd_o.mul_hi    = 1'b1;
      dpb_pkg::ST_ROUND:     cmd_o.round     = 1'b1;
      dpb_pkg::ST_EMIT:      cmd_o.emit      = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpb_pkg::ST_IDLE;
      axis_q  <= dpb_pkg::AXIS_COL;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/dpb_dp.sv @@
`default_nettype none

module dpb_dp #(
  parameter int unsigned MAX_DIM = dpb_pkg::MaxDimDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [dpb_pkg::DepthW-1:0]          depth_mm_i,
  input  wire logic                                frame_start_i,
  input  wire dpb_pkg::cfg_t                       cfg_i,
  input  wire dpb_pkg::cmd_t                       cmd_i,
  output dpb_pkg::stat_t                           stat_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [dpb_pkg::CoordW-1:0]        point_x_o,
  output logic signed [dpb_pkg::CoordW-1:0]        point_y_o,
  output logic [dpb_pkg::DepthW-1:0]               point_z_o,
  output logic [dpb_pkg::PixW-1:0]                 pixel_col_o,
  output logic [dpb_pkg::PixW-1:0]                 pixel_row_o
);

  localparam int unsigned CntW    = $clog2(MAX_DIM);
  localparam int unsigned MagW    = (CntW + 4 > dpb_pkg::CenterW) ? CntW + 4 : dpb_pkg::CenterW;
  localparam int unsigned Prod1W  = MagW + dpb_pkg::DepthW;
  localparam int unsigned HalfW   = (Prod1W + 1) / 2;
  localparam int unsigned AccW    = Prod1W + dpb_pkg::InvW;
  localparam int unsigned RndW    = AccW + 1 - dpb_pkg::RoundShift;
  localparam int unsigned MulAW   = (MagW > HalfW) ? MagW : HalfW;
  localparam int unsigned MulBW   = dpb_pkg::InvW;
  localparam int unsigned MulW    = MulAW + MulBW;
  localparam int unsigned DimExtW = (CntW + 1 > dpb_pkg::DimW) ? CntW + 1 : dpb_pkg::DimW;

  localparam logic [DimExtW-1:0] DimLimit = DimExtW'(MAX_DIM);

  logic [CntW-1:0]                col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [CntW-1:0]                col_q, row_q;
  logic [dpb_pkg::DepthW-1:0]     depth_q;
  logic                           neg_q;
  logic [Prod1W-1:0]              prod_q;
  logic [AccW-1:0]                acc_q;
  logic [dpb_pkg::CoordW-1:0]     x_q, y_q;
  logic                           out_valid_q;
  logic [dpb_pkg::CoordW-1:0]     out_x_q, out_y_q;
  logic [dpb_pkg::DepthW-1:0]     out_z_q;
  logic [dpb_pkg::PixW-1:0]       out_col_q, out_row_q;

  logic [CntW-1:0]                pos_col, pos_row;
  logic [DimExtW-1:0]             w_ext, h_ext, eff_w, eff_h, col_inc, row_inc;
  logic                           wrap_col, wrap_row;
  logic [CntW-1:0]                pos_sel;
  logic [dpb_pkg::CenterW-1:0]    center_sel;
  logic [dpb_pkg::InvW-1:0]       inv_sel;
  logic [MagW-1:0]                p16, c_ext, mag;
  logic                           diff_neg;
  logic [MulAW-1:0]               mul_a;
  logic [MulBW-1:0]               mul_b;
  logic [MulW-1:0]                mul_p;
  logic [AccW:0]                  rnd_sum;
  logic [RndW-1:0]                rnd, sat_neg;
  logic [dpb_pkg::CoordW-1:0]     res;

  // Pixel is kept when its depth is present and within range.
  assign stat_o.keep     = (depth_mm_i != '0) && (depth_mm_i <= cfg_i.max_depth);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Position of this pixel and the counter advance after it.
  always_comb begin
    pos_col  = frame_start_i ? '0 : col_cnt_q;
    pos_row  = frame_start_i ? '0 : row_cnt_q;
    w_ext    = DimExtW'(cfg_i.frame_width);
    h_ext    = DimExtW'(cfg_i.frame_height);
    eff_w    = (w_ext == '0) ? DimExtW'(1) : ((w_ext > DimLimit) ? DimLimit : w_ext);
    eff_h    = (h_ext == '0) ? DimExtW'(1) : ((h_ext > DimLimit) ? DimLimit : h_ext);
    col_inc  = DimExtW'(pos_col) + DimExtW'(1);
    row_inc  = DimExtW'(pos_row) + DimExtW'(1);
    wrap_col = col_inc >= eff_w;
    wrap_row = row_inc >= eff_h;
    col_cnt_d = wrap_col ? '0 : col_inc[CntW-1:0];
    if (wrap_col) begin
      row_cnt_d = wrap_row ? '0 : row_inc[CntW-1:0];
    end else begin
      row_cnt_d = pos_row;
    end
  end

  // Offset from the optical center, as sign and magnitude in 1/16 pixel.
  always_comb begin
    if (cmd_i.axis == dpb_pkg::AXIS_ROW) begin
      pos_sel    = row_q;
      center_sel = cfg_i.center_row;
      inv_sel    = cfg_i.inv_focal_row;
    end else begin
      pos_sel    = col_q;
      center_sel = cfg_i.center_col;
      inv_sel    = cfg_i.inv_focal_col;
    end
    p16      = MagW'({pos_sel, 4'b0000});
    c_ext    = MagW'(center_sel);
    diff_neg = p16 < c_ext;
    mag      = diff_neg ? (c_ext - p16) : (p16 - c_ext);
  end

  // Shared multiplier: offset times depth, then that product in two halves
  // times the reciprocal focal length.
  always_comb begin
    if (cmd_i.mul_depth) begin
      mul_a = MulAW'(mag);
      mul_b = MulBW'(depth_q);
    end else if (cmd_i.mul_hi) begin
      mul_a = MulAW'(prod_q[Prod1W-1:HalfW]);
      mul_b = inv_sel;
    end else begin
      mul_a = MulAW'(prod_q[HalfW-1:0]);
      mul_b = inv_sel;
    end
  end

  assign mul_p = MulW'(mul_a) * MulW'(mul_b);

  // Round to nearest with ties away from zero, apply the sign and saturate.
  always_comb begin
    rnd_sum = {1'b0, acc_q} + ({{AccW{1'b0}}, 1'b1} << (dpb_pkg::RoundShift - 1));
    rnd     = rnd_sum[AccW:dpb_pkg::RoundShift];
    sat_neg = (rnd > RndW'(dpb_pkg::NegMagLimit)) ? RndW'(dpb_pkg::NegMagLimit) : rnd;
    if (neg_q) begin
      res = '0 - sat_neg[dpb_pkg::CoordW-1:0];
    end else if (rnd > RndW'(dpb_pkg::PosMagLimit)) begin
      res = dpb_pkg::PosMagLimit[dpb_pkg::CoordW-1:0];
    end else begin
      res = rnd[dpb_pkg::CoordW-1:0];
    end
  end

  // Position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (cmd_i.capture) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      depth_q <= depth_mm_i;
      col_q   <= pos_col;
      row_q   <= pos_row;
    end
    if (cmd_i.mul_depth) begin
      prod_q <= mul_p[Prod1W-1:0];
      neg_q  <= diff_neg;
    end
    if (cmd_i.mul_lo) begin
      acc_q <= AccW'(mul_p);
    end else if (cmd_i.mul_hi) begin
      acc_q <= acc_q + (AccW'(mul_p) << HalfW);
    end
    if (cmd_i.round) begin
      if (cmd_i.axis == dpb_pkg::AXIS_ROW) begin
        y_q <= res;
      end else begin
        x_q <= res;
      end
    end
  end

  // Output register holds a finished item while the next one is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_q   <= x_q;
      out_y_q   <= y_q;
      out_z_q   <= depth_q;
      out_col_q <= dpb_pkg::PixW'(col_q);
      out_row_q <= dpb_pkg::PixW'(row_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = signed'(out_x_q);
  assign point_y_o   = signed'(out_y_q);
  assign point_z_o   = out_z_q;
  assign pixel_col_o = out_col_q;
  assign pixel_row_o = out_row_q;

endmodule

`default_nettype wire

@@ sv/depth_pixel_backprojection.sv @@
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  depth_mm_i, frame_start_i
// out       output     out_valid_o/out_ready_i point_x_o, point_y_o, point_z_o,
//                                              pixel_col_o, pixel_row_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A pixel that gives a point passes through the accept state, four steps per axis
// (whose multiplies share one multiplier) and an emit state loading the result.
// Dropped pixels leave the block idle, so such pixels stream at one per clock.
// Reset clears the position counters, the controller and the output valid, and
// loads the configuration defaults. The output register lets the next pixel be
// taken while a point waits; a point finished while the previous one still waits
// holds the block until the output is taken.
`default_nettype none

module depth_pixel_backprojection #(
  parameter int unsigned MAX_DIM = dpb_pkg::MaxDimDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [dpb_pkg::DepthW-1:0]          depth_mm_i,
  input  wire logic                                frame_start_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [dpb_pkg::CoordW-1:0]        point_x_o,
  output logic signed [dpb_pkg::CoordW-1:0]        point_y_o,
  output logic [dpb_pkg::DepthW-1:0]               point_z_o,
  output logic [dpb_pkg::PixW-1:0]                 pixel_col_o,
  output logic [dpb_pkg::PixW-1:0]                 pixel_row_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dpb_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [dpb_pkg::CfgDataW-1:0]        cfg_data_i
);

  dpb_pkg::cfg_t  cfg;
  dpb_pkg::cmd_t  cmd;
  dpb_pkg::stat_t stat;

  // Configuration registers.
  dpb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  dpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Counters, arithmetic and output register.
  dpb_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .depth_mm_i    (depth_mm_i),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o),
    .pixel_col_o   (pixel_col_o),
    .pixel_row_o   (pixel_row_o)
  );

`ifndef SYNTHESIS
  // A missing-depth item is dropped and the block is ready again at once.
  a_drop_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && depth_mm_i == '0) |=> in_ready_o)
    else $error("dropped item did not free the input");

  // A new point appears only when the input was not ready just before it.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("point appeared without a busy cycle before it");

  // Every delivered point has a nonzero depth.
  a_z_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> point_z_o != '0)
    else $error("point delivered with zero depth");
`endif

endmodule

`default_nettype wire
